// File: rtl/trwrd_pkg.sv
// Shared types, constants and helper functions for the throttle ramp block.
// No dependencies; used by throttle_ramp_with_reverse_dwell.
`timescale 1ns / 1ps
`default_nettype none

package trwrd_pkg;

  // Full-scale command magnitude. It is kept a multiple of 100, so one percent
  // of full scale is an exact whole number of command units.
  localparam int FULL_SCALE    = 1000;
  localparam int LIMIT_PER_PCT = FULL_SCALE / 100;
  localparam int PCT_MAX       = 100;

  localparam int CMD_W   = 11;
  localparam int PCT_W   = 7;
  localparam int RATE_W  = 11;
  localparam int DWELL_W = 16;
  localparam int MODE_W  = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_FWD_LIMIT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REV_LIMIT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ACCEL     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DECEL     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DWELL     = 3'd4;

  // Target mode codes. The unused code behaves as stick tracking.
  localparam logic [MODE_W-1:0] MODE_TRACK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEUTRAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPOT    = 2'd2;

  // Register reset values.
  localparam logic [PCT_W-1:0]   FWD_LIMIT_RST = 7'd100;
  localparam logic [PCT_W-1:0]   REV_LIMIT_RST = 7'd100;
  localparam logic [RATE_W-1:0]  ACCEL_RST     = 11'd10;
  localparam logic [RATE_W-1:0]  DECEL_RST     = 11'd20;
  localparam logic [DWELL_W-1:0] DWELL_RST     = 16'd50;

  typedef logic signed [CMD_W-1:0] cmd_t;

  // Command magnitude that corresponds to a percent setting, saturated at 100%.
  function automatic logic [CMD_W+5:0] pct_to_limit(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    p = (pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct;
    return (CMD_W+6)'(p) * (CMD_W+6)'(LIMIT_PER_PCT);
  endfunction

  // One bounded step from v toward t, never past t.
  function automatic cmd_t step_toward(input cmd_t v, input cmd_t t,
                                       input logic [RATE_W-1:0] rate);
    logic signed [CMD_W+2:0] diff;
    logic signed [CMD_W+2:0] r;
    cmd_t res;
    diff = (CMD_W+3)'(t) - (CMD_W+3)'(v);
    r    = $signed({2'b00, rate});
    if (diff > r) begin
      res = CMD_W'((CMD_W+3)'(v) + r);
    end else if (diff < -r) begin
      res = CMD_W'((CMD_W+3)'(v) - r);
    end else begin
      res = t;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/throttle_ramp_with_reverse_dwell.sv
// Throttle slew-rate limiter with a neutral dwell on direction reversal.
// Depends on trwrd_pkg for constants, register indexes and step helpers.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+----------------------------------
// in_       | input     | in_tvalid / in_tready       | tdata: stick, hold; tuser: mode
// out_      | output    | out_tvalid / out_tready     | tdata: ramped cmd; tuser: dwell
// cfg_      | input     | cfg_we (no wait)            | cfg_addr, cfg_wdata
//
// One item per clock is sustained while the output does not stall. An item
// waits in the input register, where the cap, mode select and ramp step are
// computed against the kept command, and then sits in the result register
// until it is taken. out_tvalid rises when the item is loaded into the result
// register, so the result cannot be taken before it has passed through both
// registers. A stall on the output backs up through the result register into
// the input register; in_tready drops only when both hold an item. Reset
// (rst_n low, synchronous) empties both stages, sets the kept command to
// neutral, clears the dwell counter and loads the register defaults.
module throttle_ramp_with_reverse_dwell (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input channel.
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [trwrd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [10:0] stick_command, [21:11] hold_command
  input  wire  [trwrd_pkg::MODE_W-1:0]       in_tuser,   // [1:0] target_mode
  // Result channel.
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [trwrd_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [10:0] ramped_command
  output logic                               out_tuser,  // [0] dwell_active
  // Configuration write port.
  input  wire                                cfg_we,
  input  wire  [trwrd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [trwrd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = trwrd_pkg::CMD_W;

  // Configuration registers.
  logic [trwrd_pkg::PCT_W-1:0]   fwd_pct_r;
  logic [trwrd_pkg::PCT_W-1:0]   rev_pct_r;
  logic [trwrd_pkg::RATE_W-1:0]  accel_r;
  logic [trwrd_pkg::RATE_W-1:0]  decel_r;
  logic [trwrd_pkg::DWELL_W-1:0] dwell_frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_pct_r      <= trwrd_pkg::FWD_LIMIT_RST;
      rev_pct_r      <= trwrd_pkg::REV_LIMIT_RST;
      accel_r        <= trwrd_pkg::ACCEL_RST;
      decel_r        <= trwrd_pkg::DECEL_RST;
      dwell_frames_r <= trwrd_pkg::DWELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        trwrd_pkg::REG_FWD_LIMIT: fwd_pct_r      <= cfg_wdata[trwrd_pkg::PCT_W-1:0];
        trwrd_pkg::REG_REV_LIMIT: rev_pct_r      <= cfg_wdata[trwrd_pkg::PCT_W-1:0];
        trwrd_pkg::REG_ACCEL:     accel_r        <= cfg_wdata[trwrd_pkg::RATE_W-1:0];
        trwrd_pkg::REG_DECEL:     decel_r        <= cfg_wdata[trwrd_pkg::RATE_W-1:0];
        trwrd_pkg::REG_DWELL:     dwell_frames_r <= cfg_wdata[trwrd_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic                          a_valid_r;
  trwrd_pkg::cmd_t               a_stick_r;
  trwrd_pkg::cmd_t               a_hold_r;
  logic [trwrd_pkg::MODE_W-1:0]  a_mode_r;

  // Result register stage.
  logic                          b_valid_r;
  trwrd_pkg::cmd_t               b_cmd_r;
  logic                          b_dwell_r;

  // Kept state.
  trwrd_pkg::cmd_t               cur_r;
  trwrd_pkg::cmd_t               cur_nxt;
  logic [trwrd_pkg::DWELL_W-1:0] dwell_left_r;
  logic [trwrd_pkg::DWELL_W-1:0] dwell_left_nxt;
  logic                          active_nxt;

  logic b_free;
  logic a_move;

  assign b_free    = !b_valid_r || out_tready;
  assign a_move    = a_valid_r && b_free;
  assign in_tready = !a_valid_r || b_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_stick_r <= in_tdata[CW-1:0];
      a_hold_r  <= in_tdata[2*CW-1:CW];
      a_mode_r  <= in_tuser;
    end
  end

  // Cap the stick command, pick the target, then take one ramp step, or hold neutral during a dwell.
  logic [CW+5:0]          fwd_lim;
  logic [CW+5:0]          rev_lim;
  logic signed [CW+6:0]   stick_w;
  trwrd_pkg::cmd_t        stick_cap;
  trwrd_pkg::cmd_t        target;
  logic [CW-1:0]          mag_t;
  logic [CW-1:0]          mag_v;
  logic                   reversal;
  trwrd_pkg::cmd_t        to_zero;

  always_comb begin
    fwd_lim = trwrd_pkg::pct_to_limit(fwd_pct_r);
    rev_lim = trwrd_pkg::pct_to_limit(rev_pct_r);
    stick_w = (CW+7)'(a_stick_r);

    if (stick_w > $signed({1'b0, fwd_lim})) begin
      stick_cap = CW'(fwd_lim);
    end else if (stick_w < -$signed({1'b0, rev_lim})) begin
      stick_cap = CW'(-$signed({1'b0, rev_lim}));
    end else begin
      stick_cap = a_stick_r;
    end

    case (a_mode_r)
      trwrd_pkg::MODE_NEUTRAL: target = '0;
      trwrd_pkg::MODE_SPOT:    target = a_hold_r;
      default:                 target = stick_cap;
    endcase

    // Magnitudes of an 11-bit signed value fit in 11 unsigned bits.
    mag_t = target[CW-1] ? CW'(-target) : CW'(target);
    mag_v = cur_r[CW-1]  ? CW'(-cur_r)  : CW'(cur_r);

    // The target points the other way from the present spin.
    reversal = (target != '0) && (cur_r != '0) && (target[CW-1] != cur_r[CW-1]);
    to_zero  = trwrd_pkg::step_toward(cur_r, '0, decel_r);

    cur_nxt        = cur_r;
    dwell_left_nxt = dwell_left_r;
    active_nxt     = 1'b0;
    if (dwell_left_r != '0) begin
      // Dwell holds neutral regardless of the target.
      cur_nxt        = '0;
      dwell_left_nxt = dwell_left_r - 1'b1;
      active_nxt     = 1'b1;
    end else if (reversal) begin
      // Ramp down first; the frame that lands on neutral arms the dwell.
      cur_nxt = to_zero;
      if (to_zero == '0) begin
        dwell_left_nxt = dwell_frames_r;
      end
    end else begin
      cur_nxt = trwrd_pkg::step_toward(cur_r, target,
                                       (mag_t >= mag_v) ? accel_r : decel_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      dwell_left_r <= '0;
    end else if (a_move) begin
      cur_r        <= cur_nxt;
      dwell_left_r <= dwell_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_cmd_r   <= cur_nxt;
      b_dwell_r <= active_nxt;
    end
  end

  assign out_tvalid = b_valid_r;
  assign out_tdata  = {{(trwrd_pkg::OUT_TDATA_W-CW){1'b0}}, b_cmd_r};
  assign out_tuser  = b_dwell_r;

  // While a dwell count remains, the kept command must sit at neutral.
  a_dwell_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (dwell_left_r != '0) |-> (cur_r == '0))
    else $error("dwell pending while command is away from neutral");

  // A result flagged as dwell always carries a neutral command.
  a_dwell_out: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_dwell_r) |-> (b_cmd_r == '0))
    else $error("dwell result with nonzero command");

  // Reset leaves both pipeline stages empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!a_valid_r && !b_valid_r))
    else $error("pipeline not empty after reset");

  // A new dwell is only armed from a frame that lands on neutral.
  a_dwell_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && dwell_left_r == '0 && dwell_left_nxt != '0) |-> (cur_nxt == '0))
    else $error("dwell armed away from neutral");

endmodule

`default_nettype wire

// File: dv/ramp_checker.sv
// Checker for the throttle ramp block: it watches the config port and both streams,
// predicts each result from its own copy of the registers and state, and compares.
// Depends on trwrd_pkg for widths, register indexes and mode codes.
`timescale 1ns / 1ps

module ramp_checker
  import trwrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [10:0] stick_command, [21:11] hold_command
  input  logic [MODE_W-1:0]      in_tuser,   // [1:0] target_mode
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [10:0] ramped_command
  input  logic                   out_tuser,  // [0] dwell_active
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     results_owed,
  output int                     results_checked,
  output int                     dwell_results
);

  localparam int PERCENT = 100;

  typedef struct packed {
    cmd_t              stick;
    logic [MODE_W-1:0] mode;
    cmd_t              hold;
  } frame_t;

  typedef struct packed {
    cmd_t ramped;
    logic dwell;
  } ramp_result_t;

  // Shadow registers and the kept state of the ramp.
  logic [PCT_W-1:0]   fwd_pct;
  logic [PCT_W-1:0]   rev_pct;
  logic [RATE_W-1:0]  accel;
  logic [RATE_W-1:0]  decel;
  logic [DWELL_W-1:0] dwell_len;
  cmd_t               kept_cmd;
  logic [DWELL_W-1:0] hold_left;

  ramp_result_t ramp_results_due[$];

  initial begin
    mismatches      = 0;
    results_owed    = 0;
    results_checked = 0;
    dwell_results   = 0;
  end

  // Moves v toward t by at most rate, landing on t when it is close enough.
  function automatic int slew(input int v, input int t, input int rate);
    if (t > v) return (t - v > rate) ? v + rate : t;
    if (t < v) return (v - t > rate) ? v - rate : t;
    return v;
  endfunction

  // Advances the kept command by one frame and returns what the block should report.
  function automatic ramp_result_t slew_frame(input frame_t f);
    ramp_result_t r;
    int fwd_cap, rev_cap, stick, target, v, rate, mag_t, mag_v;
    fwd_cap = ((fwd_pct > PERCENT) ? PERCENT : int'(fwd_pct)) * FULL_SCALE / PERCENT;
    rev_cap = ((rev_pct > PERCENT) ? PERCENT : int'(rev_pct)) * FULL_SCALE / PERCENT;
    stick = int'(f.stick);
    if (stick > fwd_cap) stick = fwd_cap;
    else if (stick < -rev_cap) stick = -rev_cap;
    case (f.mode)
      MODE_NEUTRAL: target = 0;
      MODE_SPOT:    target = int'(f.hold);
      default:      target = stick;
    endcase
    v = int'(kept_cmd);
    r.dwell = 1'b0;
    if (hold_left != 0) begin
      v = 0;
      hold_left = hold_left - 1'b1;
      r.dwell = 1'b1;
    end else if (target != 0 && v != 0 && ((target > 0) != (v > 0))) begin
      // Opposing target: come back to neutral first, then start the dwell.
      v = slew(v, 0, int'(decel));
      if (v == 0) hold_left = dwell_len;
    end else begin
      mag_t = (target < 0) ? -target : target;
      mag_v = (v < 0) ? -v : v;
      rate = (mag_t >= mag_v) ? int'(accel) : int'(decel);
      v = slew(v, target, rate);
    end
    kept_cmd = cmd_t'(v);
    r.ramped = cmd_t'(v);
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t ns checker: %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    frame_t       f;
    ramp_result_t got;
    ramp_result_t want;
    if (!rst_n) begin
      fwd_pct   = FWD_LIMIT_RST;
      rev_pct   = REV_LIMIT_RST;
      accel     = ACCEL_RST;
      decel     = DECEL_RST;
      dwell_len = DWELL_RST;
      kept_cmd  = '0;
      hold_left = '0;
      ramp_results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.ramped = cmd_t'(out_tdata[CMD_W-1:0]);
        got.dwell  = out_tuser;
        results_checked++;
        if (ramp_results_due.size() == 0) begin
          report("result with no frame waiting", int'(got.ramped), 0);
        end else begin
          want = ramp_results_due.pop_front();
          if (got.ramped !== want.ramped)
            report("ramped_command mismatch", int'(got.ramped), int'(want.ramped));
          if (got.dwell !== want.dwell)
            report("dwell_active mismatch", int'(got.dwell), int'(want.dwell));
          if (want.dwell) dwell_results++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_FWD_LIMIT: fwd_pct   = cfg_wdata[PCT_W-1:0];
          REG_REV_LIMIT: rev_pct   = cfg_wdata[PCT_W-1:0];
          REG_ACCEL:     accel     = cfg_wdata[RATE_W-1:0];
          REG_DECEL:     decel     = cfg_wdata[RATE_W-1:0];
          REG_DWELL:     dwell_len = cfg_wdata[DWELL_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        f.stick = cmd_t'(in_tdata[CMD_W-1:0]);
        f.hold  = cmd_t'(in_tdata[2*CMD_W-1:CMD_W]);
        f.mode  = in_tuser;
        ramp_results_due.push_back(slew_frame(f));
      end
    end
    results_owed <= ramp_results_due.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the throttle ramp testbench: clock, reset, stimulus, register settings and verdict.
// Depends on trwrd_pkg, throttle_ramp_with_reverse_dwell and ramp_checker.
`timescale 1ns / 1ps

module testbench;
  import trwrd_pkg::*;

  // The fourth mode code is unused by the block and must act as stick tracking.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 200;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [10:0] stick_command, [21:11] hold_command
  logic [MODE_W-1:0]      in_tuser = '0;   // [1:0] target_mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [10:0] ramped_command
  logic                   out_tuser;       // [0] dwell_active
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int results_owed;
  int results_checked;
  int dwell_results;

  // Frames sent so far and the number of register settings the run went through.
  int frames_sent = 0;
  int settings_used = 0;

  // Set by the stimulus to ask the result sink for one long hold-off.
  bit backpressure_req = 1'b0;

  // Random frames come in segments: a stretch of similar commands in one mode,
  // so the ramp has time to travel and reversals land instead of being noise.
  int                seg_left = 0;
  int                seg_stick = 0;
  int                seg_hold = 0;
  logic [MODE_W-1:0] seg_mode = MODE_TRACK;

  always #6 clk = ~clk;

  throttle_ramp_with_reverse_dwell u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ramp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .results_owed    (results_owed),
    .results_checked (results_checked),
    .dwell_results   (dwell_results)
  );

  // Sender gap after a frame: mostly none or short, a few long, none in a burst.
  function automatic int send_gap(input bit bursty);
    int roll;
    roll = $urandom_range(0, 99);
    if (bursty || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Register value that favors the two ends of its range.
  function automatic int pick_setting(input int lo, input int hi);
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int clamp_cmd(input int v);
    if (v > 1023) return 1023;
    if (v < -1024) return -1024;
    return v;
  endfunction

  // Offers one frame and returns right after the edge that took it. The valid
  // is left high when no gap follows, so back-to-back frames never drop it.
  task automatic send_frame(input int stick, input logic [MODE_W-1:0] mode, input int hold,
                            input bit bursty);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, cmd_t'(hold), cmd_t'(stick)};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    frames_sent++;
    gap = send_gap(bursty);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has come back, then
  // lets the block's two-stage pipeline settle.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges. Only called while idle.
  task automatic load_settings(input int fwd, input int rev, input int acc, input int dec,
                               input int dwell);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FWD_LIMIT;
    cfg_wdata <= CFG_DATA_W'(fwd);
    @(posedge clk);
    cfg_addr  <= REG_REV_LIMIT;
    cfg_wdata <= CFG_DATA_W'(rev);
    @(posedge clk);
    cfg_addr  <= REG_ACCEL;
    cfg_wdata <= CFG_DATA_W'(acc);
    @(posedge clk);
    cfg_addr  <= REG_DECEL;
    cfg_wdata <= CFG_DATA_W'(dec);
    @(posedge clk);
    cfg_addr  <= REG_DWELL;
    cfg_wdata <= CFG_DATA_W'(dwell);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random frames for one phase. Most follow the current segment with a little
  // jitter; about one in ten is pure noise over the whole field range.
  task automatic random_frames(input int count, input bit bursty, input int pause_at);
    int roll, stick, hold, mag;
    logic [MODE_W-1:0] mode;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 24);
        roll = $urandom_range(0, 99);
        if (roll < 8) mag = $urandom_range(1001, 1024);
        else if (roll < 22) mag = 1000;
        else if (roll < 37) mag = $urandom_range(1, 20);
        else mag = $urandom_range(1, 1000);
        // A random sign means about half the segments reverse the spin.
        seg_stick = $urandom_range(0, 1) ? clamp_cmd(mag) : -mag;
        seg_hold  = int'($urandom_range(0, 2047)) - 1024;
        roll = $urandom_range(0, 99);
        if (roll < 68) seg_mode = MODE_TRACK;
        else if (roll < 80) seg_mode = MODE_NEUTRAL;
        else if (roll < 92) seg_mode = MODE_SPOT;
        else seg_mode = MODE_UNUSED;
      end
      seg_left--;
      if ($urandom_range(0, 9) == 0) begin
        stick = int'($urandom_range(0, 2047)) - 1024;
        hold  = int'($urandom_range(0, 2047)) - 1024;
        mode  = MODE_W'($urandom_range(0, 3));
      end else begin
        stick = clamp_cmd(seg_stick + int'($urandom_range(0, 6)) - 3);
        hold  = clamp_cmd(seg_hold + int'($urandom_range(0, 6)) - 3);
        mode  = seg_mode;
      end
      send_frame(stick, mode, hold, bursty);
    end
  endtask

  // Directed frames, run with caps of 127% forward (acts as 100%) and 60%
  // reverse, accel 300, decel 400 and a two-frame dwell. They walk through a
  // forward ramp with the cap, the unused mode, a reversal that lands and
  // starts the dwell, the dwell overriding opposite and spot-lock targets, an
  // uncapped spot-lock command at both field extremes, a forced-neutral
  // decel, a move out of neutral that is no reversal, and a one-unit reversal.
  int dir_stick[25] = '{1023, 1000, 1000, 1000, -1024, -1000, 0, 1000, 0, 0,
                        0, 0, 0, 0, 0, 0, -1000, -1000, -1, 0,
                        1, -1, 0, 500, 500};
  logic [MODE_W-1:0] dir_mode[25] = '{MODE_TRACK, MODE_TRACK, MODE_UNUSED, MODE_TRACK,
                                      MODE_TRACK, MODE_TRACK, MODE_SPOT, MODE_TRACK,
                                      MODE_SPOT, MODE_SPOT, MODE_SPOT, MODE_SPOT,
                                      MODE_SPOT, MODE_NEUTRAL, MODE_NEUTRAL, MODE_NEUTRAL,
                                      MODE_TRACK, MODE_TRACK, MODE_TRACK, MODE_TRACK,
                                      MODE_TRACK, MODE_TRACK, MODE_NEUTRAL, MODE_UNUSED,
                                      MODE_TRACK};
  int dir_hold[25] = '{0, 341, -682, 0, 0, 0, -1024, 0, 1023, 1023,
                       1023, 1023, 1023, 0, 0, 0, 0, 0, 0, 0,
                       0, 0, 0, 0, 0};

  // Result sink: random stalls with long free-running stretches, and one long
  // hold-off on request so that both pipeline stages fill and in_tready drops.
  initial begin : result_sink
    int stall_left, free_run, roll;
    stall_left = 0;
    free_run = 0;
    forever begin
      @(posedge clk);
      if (backpressure_req) begin
        backpressure_req = 1'b0;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (free_run > 0) begin
          free_run--;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 10) free_run = $urandom_range(30, 120);
          else if (roll >= 55 && roll < 92) stall_left = $urandom_range(1, 3);
          else if (roll >= 92) stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  initial begin : stimulus
    int fwd, rev, acc, dec, dwell;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(127, 60, 300, 400, 2);
    for (int i = 0; i < 25; i++) send_frame(dir_stick[i], dir_mode[i], dir_hold[i], 1'b0);
    drain();

    for (int p = 1; p <= N_PHASES; p++) begin
      case (p)
        // The reset values, with the sender running flat out into a long hold-off.
        1: begin fwd = 100; rev = 100; acc = 10; dec = 20; dwell = 50; end
        // No stick authority at all and the fastest rates: only spot lock moves it.
        2: begin fwd = 0; rev = 0; acc = 2047; dec = 2047; dwell = 0; end
        // Zero rates freeze the command wherever it stands.
        3: begin fwd = 127; rev = 127; acc = 0; dec = 0; dwell = 3; end
        4: begin fwd = 100; rev = 37; acc = 1; dec = 2047; dwell = 5; end
        default: begin
          fwd   = pick_setting(0, 127);
          rev   = pick_setting(0, 127);
          acc   = ($urandom_range(0, 2) == 0) ? pick_setting(0, 2047) : $urandom_range(1, 400);
          dec   = ($urandom_range(0, 2) == 0) ? pick_setting(0, 2047) : $urandom_range(1, 400);
          dwell = $urandom_range(0, 12);
        end
      endcase
      load_settings(fwd, rev, acc, dec, dwell);
      if (p == 1) backpressure_req = 1'b1;
      // Phase three stops after its first 60 frames until every result is back, then resumes.
      random_frames(PHASE_ITEMS, (p == 1) || (p == 6), (p == 3) ? 60 : -1);
      drain();
    end

    // Longest dwell last: once a reversal lands here, the rest stays at neutral.
    load_settings(pick_setting(0, 127), pick_setting(0, 127), $urandom_range(50, 300),
                  $urandom_range(50, 300), 65535);
    random_frames(40, 1'b0, -1);
    drain();

    $display("Run covered %0d frames under %0d register settings; %0d results checked,",
             frames_sent, settings_used, results_checked);
    $display("%0d of them held at neutral by the reversal dwell.", dwell_results);
    if (mismatches == 0 && results_owed == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legal run.
  initial begin : watchdog
    #24000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/trwrd_pkg.sv
rtl/throttle_ramp_with_reverse_dwell.sv
dv/ramp_checker.sv
dv/testbench.sv
